@@ design/ste_pkg.sv @@
package ste_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [9:0] X_BIAS        = 10'd33;
  localparam logic [9:0] FLIP_X_BIG    = 10'd256;
  localparam logic [9:0] FLIP_Y_BIG    = 10'd224;
  localparam logic [9:0] FLIP_X_WIDE   = 10'd280;
  localparam logic [9:0] FLIP_X_NARROW = 10'd272;
  localparam logic [9:0] FLIP_Y_TALL   = 10'd248;
  localparam logic [9:0] FLIP_Y_SHORT  = 10'd240;
  localparam logic [4:0] COLOUR_BIAS   = 5'd16;

  // size field, low four bits, for sizes below 32x32
  localparam logic [3:0] SIZE_16X16 = 4'h0;
  localparam logic [3:0] SIZE_16X8  = 4'h4;
  localparam logic [3:0] SIZE_8X16  = 4'h8;

  localparam logic [3:0] SUB_X_OFF [4] = '{4'd0, 4'd1, 4'd4, 4'd5};
  localparam logic [3:0] SUB_Y_OFF [4] = '{4'd0, 4'd2, 4'd8, 4'd10};

  // one classified sprite, as queued between front and back
  typedef struct packed {
    logic [11:0]       code;
    logic [4:0]        colour;
    logic signed [9:0] x;
    logic signed [9:0] y;
    logic [1:0]        wm1;
    logic [1:0]        hm1;
    logic              mx;
    logic              my;
  } job_t;

endpackage

@@ design/ste_in_if.sv @@
interface ste_in_if;
  logic       valid;
  logic       ready;
  logic [11:0] sprite_code;
  logic [3:0] palette_bank;
  logic [8:0] raw_x;
  logic [7:0] raw_y;
  logic [4:0] size_code;
  logic       screen_flipped;
  logic       mirror_x;
  logic       mirror_y;

  modport source (
    output valid, sprite_code, palette_bank, raw_x, raw_y, size_code,
           screen_flipped, mirror_x, mirror_y,
    input  ready
  );
  modport sink (
    input  valid, sprite_code, palette_bank, raw_x, raw_y, size_code,
           screen_flipped, mirror_x, mirror_y,
    output ready
  );
endinterface

@@ design/ste_out_if.sv @@
interface ste_out_if;
  logic              valid;
  logic              ready;
  logic [12:0]       tile_number;
  logic [4:0]        tile_colour;
  logic signed [9:0] pos_x;
  logic signed [9:0] pos_y;
  logic              draw_mirror_x;
  logic              draw_mirror_y;
  logic              last_tile;

  modport source (
    output valid, tile_number, tile_colour, pos_x, pos_y, draw_mirror_x,
           draw_mirror_y, last_tile,
    input  ready
  );
  modport sink (
    input  valid, tile_number, tile_colour, pos_x, pos_y, draw_mirror_x,
           draw_mirror_y, last_tile,
    output ready
  );
endinterface

@@ design/ste_front.sv @@
module ste_front import ste_pkg::*; (
  ste_in_if.sink     in_bus,
  output job_t       push_job,
  output logic       push_valid,
  input  logic       push_ready
);

  logic signed [9:0] x0;
  logic signed [9:0] y0;
  logic [11:0]       code_rot;

  assign in_bus.ready = push_ready;
  assign push_valid   = in_bus.valid;

  assign x0 = $signed(X_BIAS + {2'b00, in_bus.raw_x[7:0]} - {1'b0, in_bus.raw_x[8], 8'h00});
  assign y0 = $signed({2'b00, in_bus.raw_y});
  assign code_rot = {in_bus.sprite_code[9:0], in_bus.sprite_code[11:10]};

  always_comb begin
    push_job.colour = {1'b0, in_bus.palette_bank} + COLOUR_BIAS;
    push_job.mx     = in_bus.mirror_x;
    push_job.my     = in_bus.mirror_y;
    push_job.x      = x0;
    push_job.y      = y0;
    push_job.code   = code_rot;
    push_job.wm1    = 2'd0;
    push_job.hm1    = 2'd0;
    if (in_bus.size_code[4]) begin
      if (in_bus.screen_flipped) begin
        push_job.x = $signed(FLIP_X_BIG) - x0;
        push_job.y = $signed(FLIP_Y_BIG) - y0;
      end
      push_job.code = {code_rot[11:2], 2'b00};
      push_job.wm1  = 2'd3;
      push_job.hm1  = 2'd3;
    end else begin
      if (in_bus.screen_flipped) begin
        push_job.x = $signed(in_bus.size_code[3] ? FLIP_X_WIDE : FLIP_X_NARROW) - x0;
        push_job.y = $signed(in_bus.size_code[2] ? FLIP_Y_TALL : FLIP_Y_SHORT) - y0;
      end
      case (in_bus.size_code[3:0])
        SIZE_16X16: begin
          push_job.code = {code_rot[11:2], 2'b00};
          push_job.wm1  = 2'd1;
          push_job.hm1  = 2'd1;
        end
        SIZE_16X8: begin
          push_job.code = {code_rot[11:1], 1'b0};
          push_job.wm1  = 2'd1;
        end
        SIZE_8X16: begin
          push_job.code = {code_rot[11:2], 1'b0, code_rot[0]};
          push_job.hm1  = 2'd1;
        end
        default: begin
          // single 8x8 tile, code unmasked
        end
      endcase
    end
  end

endmodule

@@ design/ste_queue.sv @@
module ste_queue import ste_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  job_t push_job,
  input  logic push_valid,
  output logic push_ready,
  output job_t head_job,
  output logic head_valid,
  input  logic pop
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push;

  assign push_ready = count_r != CW'(DEPTH);
  assign head_valid = count_r != '0;
  assign head_job   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not follow push");
`endif

endmodule

@@ design/ste_back.sv @@
module ste_back import ste_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       head_job,
  input  logic       head_valid,
  output logic       pop,
  ste_out_if.source  out_bus
);

  logic [1:0]        dx_r, dx_nxt;
  logic [1:0]        dy_r, dy_nxt;
  logic              out_valid_r;
  logic [12:0]       tile_r;
  logic [4:0]        colour_r;
  logic signed [9:0] pos_x_r;
  logic signed [9:0] pos_y_r;
  logic              mx_r;
  logic              my_r;
  logic              last_r;

  logic              emit;
  logic              last;
  logic [1:0]        ex;
  logic [1:0]        ey;
  logic [12:0]       tile_nxt;

  assign emit = head_valid && (!out_valid_r || out_bus.ready);
  assign last = (dx_r == head_job.wm1) && (dy_r == head_job.hm1);
  assign pop  = emit && last;

  // mirroring swaps which sub-tile offset a slot uses, not its position
  assign ex = head_job.mx ? head_job.wm1 - dx_r : dx_r;
  assign ey = head_job.my ? head_job.hm1 - dy_r : dy_r;
  assign tile_nxt = 13'(head_job.code) + 13'(SUB_X_OFF[ex]) + 13'(SUB_Y_OFF[ey]);

  always_comb begin
    dx_nxt = dx_r;
    dy_nxt = dy_r;
    if (emit) begin
      if (last) begin
        dx_nxt = 2'd0;
        dy_nxt = 2'd0;
      end else if (dx_r == head_job.wm1) begin
        dx_nxt = 2'd0;
        dy_nxt = dy_r + 2'd1;
      end else begin
        dx_nxt = dx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dx_r        <= 2'd0;
      dy_r        <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tile_r   <= tile_nxt;
      colour_r <= head_job.colour;
      pos_x_r  <= head_job.x + $signed({5'b00000, dx_r, 3'b000});
      pos_y_r  <= head_job.y + $signed({5'b00000, dy_r, 3'b000});
      mx_r     <= head_job.mx;
      my_r     <= head_job.my;
      last_r   <= last;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.tile_number   = tile_r;
  assign out_bus.tile_colour   = colour_r;
  assign out_bus.pos_x         = pos_x_r;
  assign out_bus.pos_y         = pos_y_r;
  assign out_bus.draw_mirror_x = mx_r;
  assign out_bus.draw_mirror_y = my_r;
  assign out_bus.last_tile     = last_r;

`ifndef NO_ASSERTIONS
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (dx_r == 2'd0) && (dy_r == 2'd0))
    else $error("tile counters not cleared after last tile");
  a_dx_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (dx_r <= head_job.wm1) && (dy_r <= head_job.hm1))
    else $error("tile counter past sprite grid");
  a_last_marks_pop: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r && (last_r == $past(pop)))
    else $error("last marker does not match queue pop");
`endif

endmodule

@@ design/sprite_tile_expander_unit.sv @@
// Sprite tile expander: each accepted sprite entry yields its 8x8 tile draws
// (1, 2, 4 or 16 of them, row by row) with last_tile set on the final one.
// The front end classifies a sprite in the cycle it is accepted and drops it
// into a small queue (QUEUE_DEPTH entries), so in_bus stays ready while the
// queue has room. The back end's tile counter emits one tile per cycle from
// the queue head into an output register while out_bus.ready does not hold
// it back; a 32x32 sprite has sixteen tiles. A sprite's first tile passes
// through a queue slot and then the output register.
module sprite_tile_expander_unit import ste_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  ste_in_if.sink     in_bus,
  ste_out_if.source  out_bus
);

  job_t push_job;
  logic push_valid;
  logic push_ready;
  job_t head_job;
  logic head_valid;
  logic pop;

  ste_front u_front (
    .in_bus     (in_bus),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  ste_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .head_job   (head_job),
    .head_valid (head_valid),
    .pop        (pop)
  );

  ste_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_job   (head_job),
    .head_valid (head_valid),
    .pop        (pop),
    .out_bus    (out_bus)
  );

endmodule
